// ----- sv/hecd_pkg.sv -----
package hecd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int NUM_SLOTS       = 10;
  localparam int SLOT_W          = $clog2(NUM_SLOTS);
  localparam int CH_W            = 4;
  localparam int BYTE_W          = 8;
  localparam int OUT_W           = 32;
  localparam int CFG_DW          = 32;
  localparam int CFG_AW          = 3;

  localparam logic [BYTE_W-1:0] HASH_CHAR = 8'h23;
  localparam logic [BYTE_W-1:0] DIGIT_LO  = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI  = 8'h39;

  localparam logic [CH_W-1:0] TAP_CHANNEL    = 4'd1;
  localparam logic [CH_W-1:0] NUM_CH_RESET   = 4'd3;

  typedef enum logic [2:0] {
    EV_DATA = 3'd0,
    EV_ESC  = 3'd1,
    EV_SEL  = 3'd2,
    EV_DROP = 3'd3,
    EV_PEND = 3'd4
  } event_t;

  typedef enum logic {
    REG_NUM_CHANNELS = 1'b0,
    REG_TAP_ENABLE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              delivered;
    logic [CH_W-1:0]   dest_channel;
    logic [BYTE_W-1:0] data_byte;
    logic              tap_copy;
    event_t            event_kind;
    logic [OUT_W-1:0]  bytes_total;
    logic [OUT_W-1:0]  escapes_total;
    logic [OUT_W-1:0]  selects_total;
    logic [OUT_W-1:0]  drops_total;
    logic [OUT_W-1:0]  channel_count;
  } result_t;

endpackage

// ----- sv/hecd_if.sv -----
interface hecd_in_if import hecd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hecd_out_if import hecd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              delivered;
  logic [CH_W-1:0]   dest_channel;
  logic [BYTE_W-1:0] data_byte;
  logic              tap_copy;
  logic [2:0]        event_kind;
  logic [OUT_W-1:0]  bytes_total;
  logic [OUT_W-1:0]  escapes_total;
  logic [OUT_W-1:0]  selects_total;
  logic [OUT_W-1:0]  drops_total;
  logic [OUT_W-1:0]  channel_count;

  modport source (
    output valid, output delivered, output dest_channel, output data_byte,
    output tap_copy, output event_kind, output bytes_total, output escapes_total,
    output selects_total, output drops_total, output channel_count,
    input ready
  );
  modport sink (
    input valid, input delivered, input dest_channel, input data_byte,
    input tap_copy, input event_kind, input bytes_total, input escapes_total,
    input selects_total, input drops_total, input channel_count,
    output ready
  );
endinterface

// ----- sv/hecd_ram.sv -----
module hecd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hecd_outq.sv -----
module hecd_outq import hecd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    din,
  input  logic       pop,
  output result_t    dout,
  output logic [1:0] count
);

  result_t    ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = ent_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

// ----- sv/hash_escaped_channel_demux_core.sv -----
// Hash-escaped receive demux: takes one serial byte per word and splits the stream into up
// to ten channels. '#' opens an escape; "##" gives a literal '#' on the current channel,
// '#' plus a digit selects that channel (channel 0 after reset), '#' plus anything else is
// dropped. Each input word yields exactly one result word carrying the event kind, the
// delivery flag (payload byte on a channel below num_channels), the channel 1 tap flag, the
// running total/escape/select/drop counters and the payload count of the channel current
// after the byte. Counters are COUNT_WIDTH bits and wrap; result fields show their low 32
// bits. Throughput is one word per cycle unless the output stalls. The accept cycle decodes
// the byte and issues the per-channel count read, the next cycle adds and writes the count
// back through the registered-read counter RAM (with a bypass for back-to-back hits on one
// channel), then the result sits in a two-word output queue. Per-channel counts are cleared
// by valid bits at reset, so no clearing pass is needed. Configuration (APB, num_channels at
// 0x0, tap_enable at 0x4) is to be written while idle; the block does not enforce this.
module hash_escaped_channel_demux_core import hecd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  hecd_in_if.sink           in_ch,
  hecd_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW = COUNT_WIDTH;

  // counter stage contents, captured at input accept
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              payload;
    logic              deliv;
    logic              tap;
    logic [CH_W-1:0]   chan;
    logic [BYTE_W-1:0] data;
    event_t            kind;
    logic [CW-1:0]     total;
    logic [CW-1:0]     esc;
    logic [CW-1:0]     sel;
    logic [CW-1:0]     drop;
  } stage_t;

  function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config regs
  logic [CH_W-1:0] num_ch_r;
  logic            tap_en_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r <= NUM_CH_RESET;
      tap_en_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUM_CHANNELS: num_ch_r <= cfg_pwdata[CH_W-1:0];
        REG_TAP_ENABLE:   tap_en_r <= cfg_pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NUM_CHANNELS: cfg_prdata = CFG_DW'(num_ch_r);
      REG_TAP_ENABLE:   cfg_prdata = CFG_DW'(tap_en_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- decode stage
  logic            in_acc;
  logic            hash_seen_r, hash_seen_nxt;
  logic [CH_W-1:0] cur_ch_r, cur_ch_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   esc_r, esc_nxt;
  logic [CW-1:0]   sel_r, sel_nxt;
  logic [CW-1:0]   drop_r, drop_nxt;
  logic            is_hash, is_digit;
  event_t          kind;
  logic            payload;
  stage_t          s1_r, s1_nxt;
  logic            s1_vld_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_hash  = in_ch.rx_byte == HASH_CHAR;
  assign is_digit = (in_ch.rx_byte >= DIGIT_LO) && (in_ch.rx_byte <= DIGIT_HI);

  always_comb begin
    if (hash_seen_r) begin
      if (is_hash)       kind = EV_ESC;
      else if (is_digit) kind = EV_SEL;
      else               kind = EV_DROP;
    end else begin
      kind = is_hash ? EV_PEND : EV_DATA;
    end
    payload = (kind == EV_ESC) || (kind == EV_DATA);

    hash_seen_nxt = hash_seen_r;
    cur_ch_nxt    = cur_ch_r;
    total_nxt     = total_r;
    esc_nxt       = esc_r;
    sel_nxt       = sel_r;
    drop_nxt      = drop_r;
    if (in_acc) begin
      hash_seen_nxt = (kind == EV_PEND);
      total_nxt     = total_r + CW'(1);
      if (kind == EV_ESC)  esc_nxt  = esc_r + CW'(1);
      if (kind == EV_DROP) drop_nxt = drop_r + CW'(1);
      if (kind == EV_SEL) begin
        sel_nxt    = sel_r + CW'(1);
        cur_ch_nxt = CH_W'(in_ch.rx_byte - DIGIT_LO);
      end
    end

    s1_nxt.slot    = cur_ch_nxt[SLOT_W-1:0];
    s1_nxt.payload = payload;
    s1_nxt.deliv   = payload && (cur_ch_nxt < num_ch_r);
    s1_nxt.tap     = s1_nxt.deliv && (cur_ch_nxt == TAP_CHANNEL) && tap_en_r;
    s1_nxt.chan    = cur_ch_nxt;
    s1_nxt.data    = payload ? in_ch.rx_byte : '0;
    s1_nxt.kind    = kind;
    s1_nxt.total   = total_nxt;
    s1_nxt.esc     = esc_nxt;
    s1_nxt.sel     = sel_nxt;
    s1_nxt.drop    = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seen_r <= 1'b0;
      cur_ch_r    <= '0;
      total_r     <= '0;
      esc_r       <= '0;
      sel_r       <= '0;
      drop_r      <= '0;
      s1_vld_r    <= 1'b0;
    end else begin
      hash_seen_r <= hash_seen_nxt;
      cur_ch_r    <= cur_ch_nxt;
      total_r     <= total_nxt;
      esc_r       <= esc_nxt;
      sel_r       <= sel_nxt;
      drop_r      <= drop_nxt;
      s1_vld_r    <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------- per-channel counts
  logic [NUM_SLOTS-1:0] slot_vld_r;
  logic                 rd_vld_r;
  logic [CW-1:0]        ram_rdata;
  logic                 wr_en;
  logic [CW-1:0]        base, cnt_new;
  logic                 byp_vld_r;
  logic [SLOT_W-1:0]    byp_slot_r;
  logic [CW-1:0]        byp_val_r;

  hecd_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_r.slot),
    .wdata (cnt_new),
    .raddr (s1_nxt.slot),
    .rdata (ram_rdata)
  );

  // a write landing on the edge that samples the read is seen only through the bypass
  always_comb begin
    if (byp_vld_r && (byp_slot_r == s1_r.slot)) base = byp_val_r;
    else if (rd_vld_r)                           base = ram_rdata;
    else                                         base = '0;
    cnt_new = s1_r.payload ? base + CW'(1) : base;
    wr_en   = s1_vld_r && s1_r.payload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      byp_vld_r  <= 1'b0;
    end else begin
      if (wr_en) slot_vld_r[s1_r.slot] <= 1'b1;
      rd_vld_r  <= slot_vld_r[s1_nxt.slot];
      byp_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    byp_slot_r <= s1_r.slot;
    byp_val_r  <= cnt_new;
  end

  // ---------------------------------------------------------------- output queue
  result_t    res, head;
  logic [1:0] q_cnt;
  logic [1:0] occ;
  logic       pop;

  always_comb begin
    res.delivered     = s1_r.deliv;
    res.dest_channel  = s1_r.chan;
    res.data_byte     = s1_r.data;
    res.tap_copy      = s1_r.tap;
    res.event_kind    = s1_r.kind;
    res.bytes_total   = to_out(s1_r.total);
    res.escapes_total = to_out(s1_r.esc);
    res.selects_total = to_out(s1_r.sel);
    res.drops_total   = to_out(s1_r.drop);
    res.channel_count = to_out(cnt_new);
  end

  hecd_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_vld_r),
    .din   (res),
    .pop   (pop),
    .dout  (head),
    .count (q_cnt)
  );

  // words in flight never exceed the queue depth
  assign pop         = out_ch.valid && out_ch.ready;
  assign occ         = q_cnt + 2'(s1_vld_r);
  assign in_ch.ready = (occ < 2'd2) || pop;

  assign out_ch.valid         = q_cnt != 2'd0;
  assign out_ch.delivered     = head.delivered;
  assign out_ch.dest_channel  = head.dest_channel;
  assign out_ch.data_byte     = head.data_byte;
  assign out_ch.tap_copy      = head.tap_copy;
  assign out_ch.event_kind    = head.event_kind;
  assign out_ch.bytes_total   = head.bytes_total;
  assign out_ch.escapes_total = head.escapes_total;
  assign out_ch.selects_total = head.selects_total;
  assign out_ch.drops_total   = head.drops_total;
  assign out_ch.channel_count = head.channel_count;

  // ---------------------------------------------------------------- checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ != 2'd3)
    else $error("output queue overcommitted");

  a_pend_sets_hash: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (kind == EV_PEND) |=> hash_seen_r)
    else $error("pending hash not recorded");

  a_no_deliv_without_payload: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_r.payload |-> !s1_r.deliv && !s1_r.tap && !wr_en)
    else $error("non-payload word delivered or counted");

  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> slot_vld_r[$past(s1_r.slot)])
    else $error("written channel count not marked valid");

endmodule
